// ===== rtl/core/tdme_pkg.sv =====
package tdme_pkg;

  localparam int unsigned DurW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ByteW   = 8;

  typedef enum logic [1:0] {
    MODE_IDLE_OUT = 2'd0,
    MODE_IDLE_IN  = 2'd1,
    MODE_STARTING = 2'd2,
    MODE_PLAYING  = 2'd3
  } tdme_mode_e;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SPI    = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_BUTTON = 2'd3
  } tdme_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PLAY_LEAD  = 3'd0,
    REG_PLAY_LOW   = 3'd1,
    REG_PLAY_HIGH  = 3'd2,
    REG_CLOCK_LOW  = 3'd3,
    REG_CLOCK_HIGH = 3'd4
  } tdme_reg_e;

  localparam logic [ByteW-1:0] BytePlayA = 8'hAC;
  localparam logic [ByteW-1:0] BytePlayB = 8'hA8;
  localparam logic [ByteW-1:0] ByteStop  = 8'h00;

  localparam logic [DurW-1:0] PlayLeadRst  = 12'd300;
  localparam logic [DurW-1:0] PlayLowRst   = 12'd337;
  localparam logic [DurW-1:0] PlayHighRst  = 12'd77;
  localparam logic [DurW-1:0] ClockLowRst  = 12'd1;
  localparam logic [DurW-1:0] ClockHighRst = 12'd25;

  typedef struct packed {
    logic [DurW-1:0] play_lead_ms;
    logic [DurW-1:0] play_low_ms;
    logic [DurW-1:0] play_high_ms;
    logic [DurW-1:0] clock_low_ms;
    logic [DurW-1:0] clock_high_ms;
  } tdme_cfg_t;

  typedef struct packed {
    tdme_mode_e mode;
    logic       switch_level;
    logic       clock_drive_low;
    logic       select_out;
    logic       led_red;
    logic       led_grn;
  } tdme_res_t;

endpackage

// ===== rtl/core/tdme_if.sv =====
interface tdme_in_if;
  import tdme_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [ByteW-1:0] spi_byte;
  logic             enable_high;

  modport source (output valid, output cmd, output spi_byte, output enable_high,
                  input ready);
  modport sink   (input valid, input cmd, input spi_byte, input enable_high,
                  output ready);
endinterface

interface tdme_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       switch_level;
  logic       clock_drive_low;
  logic       select_out;
  logic       led_red;
  logic       led_grn;

  modport source (output valid, output mode, output switch_level, output clock_drive_low,
                  output select_out, output led_red, output led_grn, input ready);
  modport sink   (input valid, input mode, input switch_level, input clock_drive_low,
                  input select_out, input led_red, input led_grn, output ready);
endinterface

interface tdme_cfg_if;
  import tdme_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DurW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tdme_ctrl.sv =====
module tdme_ctrl #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [1:0]                 cmd_i,
  input  logic [tdme_pkg::ByteW-1:0] spi_byte_i,
  input  logic                       enable_high_i,
  input  tdme_pkg::tdme_cfg_t        cfg_i,
  output tdme_pkg::tdme_res_t        res_o
);
  import tdme_pkg::*;

  localparam int unsigned CmpW = (TIMER_BITS > DurW) ? TIMER_BITS : DurW;
  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  localparam logic [1:0] SeqIdle = 2'd0;
  localparam logic [1:0] SeqLead = 2'd1;
  localparam logic [1:0] SeqLow  = 2'd2;
  localparam logic [1:0] SeqHigh = 2'd3;
  localparam logic [1:0] ClkIdle = 2'd0;
  localparam logic [1:0] ClkLow  = 2'd1;
  localparam logic [1:0] ClkHigh = 2'd2;

  function automatic logic [TIMER_BITS-1:0] sat_dur(input logic [DurW-1:0] v);
    logic [CmpW-1:0] ext;
    ext = CmpW'(v);
    if (ext > CmpW'(TimerMax)) begin
      return TimerMax;
    end
    return TIMER_BITS'(ext);
  endfunction

  tdme_mode_e            mode_q, mode_d;
  logic                  started_q, started_d;
  logic                  busy_q, busy_d;
  logic [1:0]            seq_q, seq_d;
  logic [1:0]            clkph_q, clkph_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d;
  logic                  switch_q, switch_d;
  logic                  select_q, select_d;
  logic                  clk_low_q, clk_low_d;
  logic                  red_q, red_d;
  logic                  green_q, green_d;

  always_comb begin
    logic                  run;
    logic                  eval;
    logic [DurW-1:0]       dur_raw;
    logic [TIMER_BITS-1:0] dur;
    logic [TIMER_BITS-1:0] cnt_inc;

    mode_d    = mode_q;
    started_d = started_q;
    busy_d    = busy_q;
    seq_d     = seq_q;
    clkph_d   = clkph_q;
    cnt_d     = cnt_q;
    switch_d  = switch_q;
    select_d  = select_q;
    clk_low_d = clk_low_q;
    red_d     = red_q;
    green_d   = green_q;
    run       = (seq_q != SeqIdle) || (clkph_q != ClkIdle);
    eval      = 1'b0;

    unique case (seq_q)
      SeqLead: dur_raw = cfg_i.play_lead_ms;
      SeqLow:  dur_raw = cfg_i.play_low_ms;
      SeqHigh: dur_raw = cfg_i.play_high_ms;
      default: dur_raw = (clkph_q == ClkLow) ? cfg_i.clock_low_ms : cfg_i.clock_high_ms;
    endcase
    dur     = sat_dur(dur_raw);
    cnt_inc = (cnt_q != TimerMax) ? cnt_q + 1'b1 : cnt_q;

    unique case (tdme_cmd_e'(cmd_i))
      CMD_TICK: begin
        if (started_q) begin
          if (!run) begin
            eval = 1'b1;
          end else if (cnt_inc < dur) begin
            cnt_d = cnt_inc;
          end else begin
            cnt_d = '0;
            priority if (seq_q == SeqLead) begin
              switch_d = 1'b0;
              seq_d    = SeqLow;
            end else if (seq_q == SeqLow) begin
              switch_d = 1'b1;
              seq_d    = SeqHigh;
            end else if (seq_q == SeqHigh) begin
              switch_d = 1'b0;
              seq_d    = SeqIdle;
              mode_d   = MODE_PLAYING;
              if (!busy_q) begin
                red_d     = 1'b0;
                green_d   = 1'b1;
                clk_low_d = 1'b1;
                clkph_d   = ClkLow;
              end
            end else if (clkph_q == ClkLow) begin
              clk_low_d = 1'b0;
              clkph_d   = ClkHigh;
            end else begin
              clkph_d = ClkIdle;
              eval    = 1'b1;
            end
          end
          if (eval) begin
            unique case (mode_q)
              MODE_IDLE_OUT: begin
                red_d    = 1'b1;
                green_d  = 1'b0;
                switch_d = 1'b0;
              end
              MODE_IDLE_IN: begin
                red_d    = 1'b0;
                green_d  = 1'b0;
                switch_d = 1'b1;
              end
              MODE_STARTING: begin
                seq_d = SeqLead;
                cnt_d = '0;
              end
              default: begin
                if (!busy_q) begin
                  red_d     = 1'b0;
                  green_d   = 1'b1;
                  clk_low_d = 1'b1;
                  clkph_d   = ClkLow;
                  cnt_d     = '0;
                end
              end
            endcase
          end
        end
      end
      CMD_SPI: begin
        if ((spi_byte_i == BytePlayA) || (spi_byte_i == BytePlayB)) begin
          mode_d = MODE_STARTING;
        end else if ((spi_byte_i == ByteStop) && (mode_q == MODE_PLAYING)) begin
          mode_d = MODE_IDLE_IN;
        end
      end
      CMD_ENABLE: begin
        if (enable_high_i) begin
          select_d = 1'b1;
          busy_d   = 1'b0;
        end else begin
          clk_low_d = 1'b0;
          select_d  = 1'b0;
          busy_d    = 1'b1;
        end
      end
      default: begin
        if (!started_q) begin
          started_d = 1'b1;
          switch_d  = 1'b1;
        end
      end
    endcase

    res_o.mode            = mode_d;
    res_o.switch_level    = switch_d;
    res_o.clock_drive_low = clk_low_d;
    res_o.select_out      = select_d;
    res_o.led_red         = red_d;
    res_o.led_grn         = green_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE_OUT;
      started_q <= 1'b0;
      busy_q    <= 1'b0;
      seq_q     <= SeqIdle;
      clkph_q   <= ClkIdle;
      cnt_q     <= '0;
      switch_q  <= 1'b0;
      select_q  <= 1'b1;
      clk_low_q <= 1'b0;
      red_q     <= 1'b1;
      green_q   <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      started_q <= started_d;
      busy_q    <= busy_d;
      seq_q     <= seq_d;
      clkph_q   <= clkph_d;
      cnt_q     <= cnt_d;
      switch_q  <= switch_d;
      select_q  <= select_d;
      clk_low_q <= clk_low_d;
      red_q     <= red_d;
      green_q   <= green_d;
    end
  end

endmodule

// ===== rtl/core/tape_deck_mode_emulator_core.sv =====
// channel   dir  handshake        payload
// in_i      in   valid / ready    cmd, spi_byte, enable_high
// out_o     out  valid / ready    mode, switch_level, clock_drive_low, select_out, led_*
// cfg_i     in   valid / ready    index, data (always ready)
//
// two register stages: input register, then state update and result register
// one item per cycle sustained while out_o is not stalled
// rst_ni clears all control state and reloads the duration registers
// a stalled result holds both stages; the input register still takes an item while
// the result register is full and the input register is empty
module tape_deck_mode_emulator_core #(
  parameter int unsigned TIMER_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdme_in_if.sink    in_i,
  tdme_out_if.source out_o,
  tdme_cfg_if.sink   cfg_i
);
  import tdme_pkg::*;

  tdme_cfg_t        cfg_q;
  logic             s1_valid_q;
  logic [1:0]       s1_cmd_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_en_q;
  logic             out_valid_q;
  tdme_res_t        out_q;
  tdme_res_t        res;
  logic             adv;
  logic             step;

  assign adv        = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && adv;
  assign in_i.ready = !s1_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.play_lead_ms  <= PlayLeadRst;
      cfg_q.play_low_ms   <= PlayLowRst;
      cfg_q.play_high_ms  <= PlayHighRst;
      cfg_q.clock_low_ms  <= ClockLowRst;
      cfg_q.clock_high_ms <= ClockHighRst;
    end else if (cfg_i.valid) begin
      case (tdme_reg_e'(cfg_i.index))
        REG_PLAY_LEAD:  cfg_q.play_lead_ms  <= cfg_i.data;
        REG_PLAY_LOW:   cfg_q.play_low_ms   <= cfg_i.data;
        REG_PLAY_HIGH:  cfg_q.play_high_ms  <= cfg_i.data;
        REG_CLOCK_LOW:  cfg_q.clock_low_ms  <= cfg_i.data;
        REG_CLOCK_HIGH: cfg_q.clock_high_ms <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q  <= in_i.cmd;
      s1_byte_q <= in_i.spi_byte;
      s1_en_q   <= in_i.enable_high;
    end
    if (step) begin
      out_q <= res;
    end
  end

  tdme_ctrl #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cmd_i        (s1_cmd_q),
    .spi_byte_i   (s1_byte_q),
    .enable_high_i(s1_en_q),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.mode            = out_q.mode;
  assign out_o.switch_level    = out_q.switch_level;
  assign out_o.clock_drive_low = out_q.clock_drive_low;
  assign out_o.select_out      = out_q.select_out;
  assign out_o.led_red         = out_q.led_red;
  assign out_o.led_grn         = out_q.led_grn;

endmodule
